>>> design/dtpm_pkg.sv
package dtpm_pkg;

  localparam int GRID_COLS = 40;
  localparam int GRID_ROWS = 30;

  // field widths of the ports and of the redraw counter
  localparam int POS_W      = 11;
  localparam int RECT_W_W   = 6;
  localparam int RECT_H_W   = 5;
  localparam int LVL_W      = 8;
  localparam int TILE_COL_W = 6;
  localparam int TILE_ROW_W = 5;
  localparam int TOTAL_W    = 32;

  // internal widths
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  // a segment end can reach the last column plus the widest rectangle
  localparam int SPAN_W = $clog2(GRID_COLS + (1 << RECT_W_W));

  typedef logic [LVL_W-1:0] lvl_t;
  typedef lvl_t [GRID_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_RAISE = 2'd1,
    OP_MARK  = 2'd2,
    OP_SCAN  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    K_DONE  = 2'd0,
    K_DIRTY = 2'd1,
    K_CLEAN = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ALU_SET,
    ALU_RAISE,
    ALU_MARK
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t         mode;
    logic [SPAN_W-1:0] lo;
    logic [SPAN_W-1:0] hi;
    lvl_t              level;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_NORM,
    S_SEG_RD,
    S_SEG_WR,
    S_MARK_RD,
    S_MARK_WR,
    S_SCAN_RD,
    S_SCAN_LD,
    S_SCAN_WALK,
    S_SCAN_WB,
    S_DONE
  } state_t;

endpackage

>>> design/dirty_tile_priority_map_top.sv
// channel | valid     | stall     | fields
// request | in_valid  | in_stall  | opcode pos_x pos_y in_pixels rect_width rect_height level
// result  | out_valid | out_stall | kind tile_col tile_row old_level last
//
// Tile levels live in a row-wide RAM, one grid row per word; set, raise and mark are
// read-modify-writes of one word at a time through a shared lane unit.
// Set/raise: fold the origin into row/column, then read and write each row segment
// (a rectangle row that wraps takes 2 or 3 segments). Mark all: each grid row likewise.
// Scan: read and load the row, walk its columns (held by result stalls), then write back.
// After reset a clearing pass zeroes the RAM; in_stall is high meanwhile.
// in_stall is high from acceptance until the final result is loaded.
module dirty_tile_priority_map_top import dtpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic                  in_pixels,
  input  logic [RECT_W_W-1:0]   rect_width,
  input  logic [RECT_H_W-1:0]   rect_height,
  input  logic [LVL_W-1:0]      level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [TILE_COL_W-1:0] tile_col,
  output logic [TILE_ROW_W-1:0] tile_row,
  output logic [LVL_W-1:0]      old_level,
  output logic                  last
);

  state_t state, state_next;

  opcode_t             op;
  lvl_t                lv;
  logic [RECT_W_W-1:0] rect_w;
  logic [RECT_H_W-1:0] rows_left;
  logic [POS_W-1:0]    q, q0, c;
  logic [COL_W-1:0]    c0;
  logic [RECT_W_W-1:0] rem;
  kind_t               fin_kind;

  row_t             mem [GRID_ROWS];
  row_t             rdata, wdata, alu_out, rbuf;
  logic             mem_we;
  logic [ROW_W-1:0] addr;

  logic [COL_W-1:0]   col, pend_col;
  lvl_t               pend_lvl, cur_lvl;
  logic               pend_valid;
  logic [TOTAL_W-1:0] redraw_total;

  alu_ctl_t alu_ctl;

  logic [POS_W-1:0]  x_cl, y_cl, x_eff, y_eff;
  logic              rect_empty, scan_bad;
  logic [SPAN_W-1:0] avail, rem_ext;
  logic              spill, out_free, hit, walk_go, emit_mid, emit_fin, col_end;

  assign x_cl  = pos_x[POS_W-1] ? '0 : pos_x;
  assign y_cl  = pos_y[POS_W-1] ? '0 : pos_y;
  assign x_eff = in_pixels ? (x_cl >> 4) : x_cl;
  assign y_eff = in_pixels ? (y_cl >> 4) : y_cl;

  assign rect_empty = (rect_width == '0) || (rect_height == '0);
  assign scan_bad   = pos_y[POS_W-1] || (pos_y >= POS_W'(GRID_ROWS));

  // columns left in the current grid row; more than that spills to the next row
  assign avail   = SPAN_W'(GRID_COLS) - SPAN_W'(c);
  assign rem_ext = SPAN_W'(rem);
  assign spill   = rem_ext > avail;

  assign out_free = !out_valid || !out_stall;
  assign cur_lvl  = rbuf[col];
  assign hit      = cur_lvl != '0;
  // a new hit pushes the previous one out, so it needs the output register
  assign walk_go  = !hit || !pend_valid || out_free;
  assign emit_mid = (state == S_SCAN_WALK) && hit && pend_valid && out_free;
  assign emit_fin = (state == S_DONE) && out_free;
  assign col_end  = col == COL_W'(GRID_COLS - 1);

  assign in_stall = state != S_IDLE;
  assign addr     = q[ROW_W-1:0];

  always_comb begin
    alu_ctl.level = lv;
    if (state == S_MARK_WR) begin
      alu_ctl.mode = ALU_MARK;
      alu_ctl.lo   = '0;
      alu_ctl.hi   = SPAN_W'(GRID_COLS);
    end else begin
      alu_ctl.mode = (op == OP_RAISE) ? ALU_RAISE : ALU_SET;
      alu_ctl.lo   = SPAN_W'(c);
      alu_ctl.hi   = SPAN_W'(c) + rem_ext;
    end
  end

  dtpm_row_alu u_alu (
    .ctl     (alu_ctl),
    .row_in  (rdata),
    .row_out (alu_out)
  );

  always_comb begin
    mem_we = 1'b0;
    wdata  = alu_out;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        wdata  = '0;
      end
      S_SEG_WR, S_MARK_WR: mem_we = 1'b1;
      S_SCAN_WB: begin
        mem_we = 1'b1;
        wdata  = rbuf;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (q == POS_W'(GRID_ROWS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (opcode_t'(opcode))
            OP_SET, OP_RAISE: state_next = rect_empty ? S_DONE : S_NORM;
            OP_MARK:          state_next = S_MARK_RD;
            OP_SCAN:          state_next = scan_bad ? S_DONE : S_SCAN_RD;
            default:          state_next = S_DONE;
          endcase
        end
      end
      S_NORM: begin
        if (c < POS_W'(GRID_COLS))
          state_next = (q >= POS_W'(GRID_ROWS)) ? S_DONE : S_SEG_RD;
      end
      // rows at or past the bottom: nothing further can land in the grid
      S_SEG_RD: state_next = (q >= POS_W'(GRID_ROWS)) ? S_DONE : S_SEG_WR;
      S_SEG_WR: begin
        if (!spill && rows_left == RECT_H_W'(1)) state_next = S_DONE;
        else                                     state_next = S_SEG_RD;
      end
      S_MARK_RD: state_next = S_MARK_WR;
      S_MARK_WR: state_next = (q == POS_W'(GRID_ROWS - 1)) ? S_DONE : S_MARK_RD;
      S_SCAN_RD: state_next = S_SCAN_LD;
      S_SCAN_LD: state_next = S_SCAN_WALK;
      S_SCAN_WALK: if (walk_go && col_end) state_next = S_SCAN_WB;
      S_SCAN_WB: state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q            <= '0;
      out_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      redraw_total <= '0;
    end else begin
      case (state)
        S_CLEAR: q <= q + POS_W'(1);
        S_IDLE: begin
          if (in_valid) begin
            op         <= opcode_t'(opcode);
            lv         <= level;
            rect_w     <= rect_width;
            rows_left  <= rect_height;
            c          <= x_eff;
            pend_valid <= 1'b0;
            fin_kind   <= (opcode_t'(opcode) == OP_SCAN) ? K_CLEAN : K_DONE;
            unique case (opcode_t'(opcode))
              OP_MARK: q <= '0;
              OP_SCAN: q <= pos_y;
              default: q <= y_eff;
            endcase
          end
        end
        S_NORM: begin
          if (c >= POS_W'(GRID_COLS)) begin
            c <= c - POS_W'(GRID_COLS);
            q <= q + POS_W'(1);
          end else begin
            q0  <= q;
            c0  <= c[COL_W-1:0];
            rem <= rect_w;
          end
        end
        S_SEG_WR: begin
          if (spill) begin
            rem <= rem - RECT_W_W'(avail);
            q   <= q + POS_W'(1);
            c   <= '0;
          end else begin
            rows_left <= rows_left - RECT_H_W'(1);
            q0        <= q0 + POS_W'(1);
            q         <= q0 + POS_W'(1);
            c         <= POS_W'(c0);
            rem       <= rect_w;
          end
        end
        S_MARK_WR: q <= q + POS_W'(1);
        S_SCAN_LD: begin
          rbuf <= rdata;
          col  <= '0;
        end
        S_SCAN_WALK: begin
          if (walk_go) begin
            if (hit) begin
              rbuf[col]    <= cur_lvl - LVL_W'(1);
              pend_col     <= col;
              pend_lvl     <= cur_lvl;
              pend_valid   <= 1'b1;
              redraw_total <= redraw_total + TOTAL_W'(1);
            end
            if (!col_end) col <= col + COL_W'(1);
          end
        end
        S_DONE: if (out_free) pend_valid <= 1'b0;
        default: ;
      endcase

      if (emit_mid || emit_fin) begin
        out_valid <= 1'b1;
        last      <= emit_fin;
        if (pend_valid) begin
          kind      <= K_DIRTY;
          tile_col  <= TILE_COL_W'(pend_col);
          tile_row  <= TILE_ROW_W'(q[ROW_W-1:0]);
          old_level <= pend_lvl;
        end else begin
          kind      <= fin_kind;
          tile_col  <= '0;
          tile_row  <= '0;
          old_level <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_we_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> q < POS_W'(GRID_ROWS))
    else $error("tile RAM written past the last grid row");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !pend_valid)
    else $error("request accepted with a dirty tile still pending");

  a_summary_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != K_DIRTY) |-> last)
    else $error("done/clean result not marked last");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == K_DIRTY) |-> (tile_col < TILE_COL_W'(GRID_COLS)
                                        && old_level != '0))
    else $error("dirty tile report out of range or with zero level");

endmodule

>>> design/dtpm_row_alu.sv
module dtpm_row_alu import dtpm_pkg::*; (
  input  alu_ctl_t ctl,
  input  row_t     row_in,
  output row_t     row_out
);

  always_comb begin
    for (int i = 0; i < GRID_COLS; i++) begin
      row_out[i] = row_in[i];
      unique case (ctl.mode)
        ALU_SET: begin
          if (ctl.lo <= SPAN_W'(i) && SPAN_W'(i) < ctl.hi) row_out[i] = ctl.level;
        end
        ALU_RAISE: begin
          if (ctl.lo <= SPAN_W'(i) && SPAN_W'(i) < ctl.hi && row_in[i] < ctl.level)
            row_out[i] = ctl.level;
        end
        ALU_MARK: begin
          if (row_in[i] == '0) row_out[i] = LVL_W'(1);
        end
        default: row_out[i] = row_in[i];
      endcase
    end
  end

endmodule
